// ----- rtl/ksd_pkg.sv -----
package ksd_pkg;

    // request codes
    localparam logic [1:0] REQ_CLEAR = 2'd0;
    localparam logic [1:0] REQ_LOAD  = 2'd1;
    localparam logic [1:0] REQ_QUERY = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FEW  = 2'd1;
    localparam logic [1:0] ST_ZERO = 2'd2;
    localparam logic [1:0] ST_FULL = 2'd3;

    // configuration register indexes
    localparam logic [2:0] CFG_SCALE  = 3'd0;
    localparam logic [2:0] CFG_RSTEP  = 3'd1;
    localparam logic [2:0] CFG_RSTEPS = 3'd2;
    localparam logic [2:0] CFG_NCOUNT = 3'd3;
    localparam logic [2:0] CFG_YIELD  = 3'd4;

    localparam int DIST_W = 33;   // distance, Q2.30 plus one bit
    localparam int RAD_W  = 66;   // sum of three squares
    localparam int TERM_W = 56;   // (mass * w) >> 6
    localparam int SUM_W  = 62;   // sum of up to 64 terms
    localparam int SH_W   = 5;    // normalize shift count

    localparam logic [31:0] ONE_Q30 = 32'h4000_0000;
    localparam logic [31:0] TWO_Q30 = 32'h8000_0000;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_CLEAR,
        OP_LOAD,
        OP_FULL,
        OP_ERR,
        OP_QINIT,
        OP_DIF,
        OP_SQX,
        OP_SQY,
        OP_SQZ,
        OP_SQF,
        OP_SQRT,
        OP_INS,
        OP_CHK,
        OP_RMUL,
        OP_RCMP,
        OP_ADIV0,
        OP_DIV,
        OP_W1,
        OP_W2,
        OP_W3,
        OP_W4,
        OP_AW5,
        OP_NORM,
        OP_BMUL,
        OP_BDIV0,
        OP_EMIT
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [1:0] err;
    } t_cmd;

    typedef struct packed {
        logic cnt_full;
        logic cnt_zero;
        logic scan_last;
        logic list_short;
        logic radius_fail;
        logic dmax_zero;
        logic j_last;
        logic sum_zero;
        logic sum_wide;
    } t_sts;

endpackage

// ----- rtl/knn_sph_kernel_deposit.sv -----
// Nearest-neighbor cubic-spline share deposit.
// Request channel: an item is taken at a clock edge with start high and busy
// low. req_type selects clear (store count to zero), load (append position and
// mass) or query (find the nearest neighbors of a centre and split total_yield).
// Clear and load leave busy low, so loads can follow every cycle.
// A load into a full store is dropped and answered next cycle with status 3.
// A query holds busy while it runs: for each of the N stored particles a
// one-bit-a-cycle square root, then for each of the k neighbors the
// one-bit-a-cycle divider (kernel argument, then share), with up to 30
// normalize shifts between the passes; the kernel-argument divide is skipped
// when the farthest neighbor sits on the centre. Errors end the query early.
// Results: one item per cycle-wide o_result_valid strobe, nearest first, last
// flagged; an error gives a single item with last set. The receiver cannot stall.
// Config: write channel always ready; write only while busy is low.
// Reset (synchronous, active low) empties the store, loads register defaults.
module knn_sph_kernel_deposit #(
    parameter int MAX_PARTICLES = 4096,
    parameter int MAX_NEIGHBORS = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // request channel
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_req_type,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_pos_z,
    input  logic [31:0]        i_particle_mass,
    input  logic [23:0]        i_centre_id,
    // configuration channel
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    // result channel
    output logic               o_result_valid,
    output logic [11:0]        o_neighbor_index,
    output logic [23:0]        o_echo_id,
    output logic [31:0]        o_neighbor_distance,
    output logic [31:0]        o_share,
    output logic [1:0]         o_status,
    output logic               o_last
);
    import ksd_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic cfg_we;

    // registers are plain flops, so config writes are taken every cycle
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    // sequencer: scan, threshold check, weight pass, share pass
    ksd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_req_type (i_req_type),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_busy     (busy)
    );

    // stores, sorted neighbor cells, multiplier, sqrt and divider
    ksd_dp #(
        .MAX_PARTICLES (MAX_PARTICLES),
        .MAX_NEIGHBORS (MAX_NEIGHBORS)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_valid         (cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_pos_x             (i_pos_x),
        .i_pos_y             (i_pos_y),
        .i_pos_z             (i_pos_z),
        .i_particle_mass     (i_particle_mass),
        .i_centre_id         (i_centre_id),
        .i_cmd               (cmd),
        .o_sts               (sts),
        .o_result_valid      (o_result_valid),
        .o_neighbor_index    (o_neighbor_index),
        .o_echo_id           (o_echo_id),
        .o_neighbor_distance (o_neighbor_distance),
        .o_share             (o_share),
        .o_status            (o_status),
        .o_last              (o_last)
    );

endmodule

// ----- rtl/ksd_ram.sv -----
module ksd_ram #(
    parameter int W = 32,
    parameter int D = 64
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/ksd_ctrl.sv -----
module ksd_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [1:0]    i_req_type,
    input  ksd_pkg::t_sts i_sts,
    output ksd_pkg::t_cmd o_cmd,
    output logic          o_busy
);
    import ksd_pkg::*;

    typedef enum logic [4:0] {
        IDLE,
        S_RD, S_DIF, S_SQX, S_SQY, S_SQZ, S_SQF, S_SQRT, S_INS,
        C_CHK, C_RMUL, C_RCMP,
        A_INIT, A_DIV, A_W1, A_W2, A_W3, A_W4, A_W5, A_NORM,
        B_RD, B_MUL, B_DIV0, B_DIV, B_EMIT
    } t_state;

    t_state     r_state, n_state;
    logic [5:0] r_cnt, n_cnt;
    logic       r_busy;
    t_cmd       cmd;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt + 6'd1;
        cmd     = '{op: OP_NOP, err: ST_OK};
        unique case (r_state)
            IDLE: begin
                if (i_start && !r_busy) begin
                    case (i_req_type)
                        REQ_CLEAR: cmd.op = OP_CLEAR;
                        REQ_LOAD:  cmd.op = i_sts.cnt_full ? OP_FULL : OP_LOAD;
                        REQ_QUERY: begin
                            cmd.op  = OP_QINIT;
                            n_state = i_sts.cnt_zero ? C_CHK : S_RD;
                        end
                        default: ;
                    endcase
                end
            end
            S_RD:  n_state = S_DIF;
            S_DIF: begin
                cmd.op  = OP_DIF;
                n_state = S_SQX;
            end
            S_SQX: begin
                cmd.op  = OP_SQX;
                n_state = S_SQY;
            end
            S_SQY: begin
                cmd.op  = OP_SQY;
                n_state = S_SQZ;
            end
            S_SQZ: begin
                cmd.op  = OP_SQZ;
                n_state = S_SQF;
            end
            S_SQF: begin
                cmd.op  = OP_SQF;
                n_cnt   = '0;
                n_state = S_SQRT;
            end
            S_SQRT: begin
                cmd.op = OP_SQRT;
                if (r_cnt == 6'd32) n_state = S_INS;
            end
            S_INS: begin
                cmd.op  = OP_INS;
                n_state = i_sts.scan_last ? C_CHK : S_RD;
            end
            C_CHK: begin
                if (i_sts.list_short) begin
                    cmd     = '{op: OP_ERR, err: ST_FEW};
                    n_state = IDLE;
                end else begin
                    cmd.op  = OP_CHK;
                    n_state = C_RMUL;
                end
            end
            C_RMUL: begin
                cmd.op  = OP_RMUL;
                n_state = C_RCMP;
            end
            C_RCMP: begin
                if (i_sts.radius_fail) begin
                    cmd     = '{op: OP_ERR, err: ST_FEW};
                    n_state = IDLE;
                end else begin
                    cmd.op  = OP_RCMP;
                    n_state = A_INIT;
                end
            end
            A_INIT: begin
                cmd.op  = OP_ADIV0;
                n_cnt   = '0;
                n_state = i_sts.dmax_zero ? A_W1 : A_DIV;
            end
            A_DIV: begin
                cmd.op = OP_DIV;
                if (r_cnt == 6'd31) n_state = A_W1;
            end
            A_W1: begin
                cmd.op  = OP_W1;
                n_state = A_W2;
            end
            A_W2: begin
                cmd.op  = OP_W2;
                n_state = A_W3;
            end
            A_W3: begin
                cmd.op  = OP_W3;
                n_state = A_W4;
            end
            A_W4: begin
                cmd.op  = OP_W4;
                n_state = A_W5;
            end
            A_W5: begin
                cmd.op  = OP_AW5;
                n_state = i_sts.j_last ? A_NORM : A_INIT;
            end
            A_NORM: begin
                if (i_sts.sum_zero) begin
                    cmd     = '{op: OP_ERR, err: ST_ZERO};
                    n_state = IDLE;
                end else if (i_sts.sum_wide) begin
                    cmd.op = OP_NORM;
                end else begin
                    n_state = B_RD;
                end
            end
            B_RD:  n_state = B_MUL;
            B_MUL: begin
                cmd.op  = OP_BMUL;
                n_state = B_DIV0;
            end
            B_DIV0: begin
                cmd.op  = OP_BDIV0;
                n_cnt   = '0;
                n_state = B_DIV;
            end
            B_DIV: begin
                cmd.op = OP_DIV;
                if (r_cnt == 6'd31) n_state = B_EMIT;
            end
            B_EMIT: begin
                cmd.op  = OP_EMIT;
                n_state = i_sts.j_last ? IDLE : B_RD;
            end
            default: n_state = IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= IDLE;
            r_cnt   <= '0;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_busy  <= (n_state != IDLE);
        end
    end

    assign o_cmd  = cmd;
    assign o_busy = r_busy;

endmodule

// ----- rtl/ksd_dp.sv -----
module ksd_dp #(
    parameter int MAX_PARTICLES = 4096,
    parameter int MAX_NEIGHBORS = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_pos_z,
    input  logic [31:0]        i_particle_mass,
    input  logic [23:0]        i_centre_id,
    input  ksd_pkg::t_cmd      i_cmd,
    output ksd_pkg::t_sts      o_sts,
    output logic               o_result_valid,
    output logic [11:0]        o_neighbor_index,
    output logic [23:0]        o_echo_id,
    output logic [31:0]        o_neighbor_distance,
    output logic [31:0]        o_share,
    output logic [1:0]         o_status,
    output logic               o_last
);
    import ksd_pkg::*;

    localparam int AW = $clog2(MAX_PARTICLES);
    localparam int CW = AW + 1;
    localparam int NB = MAX_NEIGHBORS;
    localparam int JW = $clog2(NB);
    localparam int KW = $clog2(NB + 1);

    function automatic logic [31:0] abs_diff(input logic [31:0] a, input logic [31:0] b);
        logic signed [32:0] df;
        logic [32:0]        mag;
        df  = $signed({a[31], a}) - $signed({b[31], b});
        mag = df[32] ? 33'(-df) : 33'(df);
        return mag[31:0];
    endfunction

    // configuration
    logic [31:0] r_scale, r_yield;
    logic [15:0] r_rstep;
    logic [3:0]  r_rsteps;
    logic [6:0]  r_ncount;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale  <= 32'd2949120000;
            r_rstep  <= 16'd512;
            r_rsteps <= 4'd7;
            r_ncount <= 7'd32;
            r_yield  <= 32'hFFFF_FFFF;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SCALE:  r_scale  <= i_cfg_data;
                CFG_RSTEP:  r_rstep  <= i_cfg_data[15:0];
                CFG_RSTEPS: r_rsteps <= i_cfg_data[3:0];
                CFG_NCOUNT: r_ncount <= i_cfg_data[6:0];
                CFG_YIELD:  r_yield  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // control-side registers
    logic [CW-1:0]   r_count;
    logic [AW-1:0]   r_i;
    logic [KW-1:0]   r_k, r_n;
    logic [JW-1:0]   r_j;
    logic [SH_W-1:0] r_s;

    // payload registers
    logic [31:0]        r_cx, r_cy, r_cz;
    logic [23:0]        r_id;
    logic [31:0]        r_dx, r_dy, r_dz;
    logic [63:0]        r_prod;
    logic [RAD_W-1:0]   r_acc, r_rad;
    logic [34:0]        r_rem;
    logic [DIST_W-1:0]  r_root;
    logic [DIST_W-1:0]  r_dmax;
    logic [DIST_W-1:0]  r_dsor, r_drem;
    logic [31:0]        r_dlo, r_quo;
    logic [30:0]        r_u, r_w;
    logic [SUM_W-1:0]   r_sum;
    logic [DIST_W-1:0]  r_cd [NB];
    logic [AW-1:0]      r_ci [NB];

    logic [95:0]        pos_rdata;
    logic [31:0]        mass_rdata;
    logic [TERM_W-1:0]  term_rdata, term;

    ksd_ram #(.W(96), .D(MAX_PARTICLES)) u_pos_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.op == OP_LOAD),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata ({i_pos_x, i_pos_y, i_pos_z}),
        .i_raddr (r_i),
        .o_rdata (pos_rdata)
    );

    ksd_ram #(.W(32), .D(MAX_PARTICLES)) u_mass_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.op == OP_LOAD),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (i_particle_mass),
        .i_raddr (r_ci[0]),
        .o_rdata (mass_rdata)
    );

    ksd_ram #(.W(TERM_W), .D(NB)) u_term_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.op == OP_AW5),
        .i_waddr (r_j),
        .i_wdata (term),
        .i_raddr (r_j),
        .o_rdata (term_rdata)
    );

    assign term = r_prod[61:6];

    // clamped neighbor count
    logic [KW-1:0] k_clamp;
    always_comb begin
        if (r_ncount < 7'd2)                    k_clamp = KW'(2);
        else if (r_ncount > 7'(MAX_NEIGHBORS)) k_clamp = KW'(MAX_NEIGHBORS);
        else                                   k_clamp = KW'(r_ncount);
    end

    // spline base: q when q is at most one, else 2 - q
    logic        q_le;
    logic [31:0] base;
    assign q_le = (r_quo <= ONE_Q30);
    assign base = q_le ? r_quo : (TWO_Q30 - r_quo);

    // shared multiplier
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    logic [31:0] term_sh;
    assign term_sh = 32'(term_rdata >> r_s);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.op)
            OP_SQX:  begin mul_a = r_dx;              mul_b = r_dx;        end
            OP_SQY:  begin mul_a = r_dy;              mul_b = r_dy;        end
            OP_SQZ:  begin mul_a = r_dz;              mul_b = r_dz;        end
            OP_RMUL: begin mul_a = r_scale;           mul_b = r_dmax[31:0]; end
            OP_W1:   begin mul_a = base;              mul_b = base;        end
            OP_W2:   begin mul_a = 32'(r_prod >> 30); mul_b = base;        end
            OP_W4:   begin mul_a = mass_rdata;        mul_b = 32'(r_w);    end
            OP_BMUL: begin mul_a = term_sh;           mul_b = r_yield;     end
            default: ;
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // square root step
    logic [36:0] rem2;
    logic [34:0] trial;
    logic        sq_ge;
    assign rem2  = {r_rem, r_rad[RAD_W-1 -: 2]};
    assign trial = {r_root, 2'b01};
    assign sq_ge = (rem2 >= 37'(trial));

    // divider step
    logic [33:0] drem2;
    logic        d_ge;
    assign drem2 = {r_drem, r_dlo[31]};
    assign d_ge  = (drem2 >= {1'b0, r_dsor});

    // spline weight
    logic [32:0]        u3, q3x3;
    logic [30:0]        q3;
    logic signed [33:0] w_poly;
    logic [30:0]        w_next;
    always_comb begin
        q3     = 31'(r_prod >> 30);
        u3     = {2'b00, r_u} + {1'b0, r_u, 1'b0};
        q3x3   = {2'b00, q3} + {1'b0, q3, 1'b0};
        w_poly = $signed({2'b00, ONE_Q30}) - $signed({2'b00, u3[32:1]})
               + $signed({3'b000, q3x3[32:2]});
        if (q_le) w_next = w_poly[33] ? 31'd0 : w_poly[30:0];
        else      w_next = 31'(r_prod >> 32);
    end

    // neighbor list cells
    logic [NB-1:0] gt;
    logic [DIST_W-1:0] dmax_sel;
    logic j_last;
    assign j_last = ((KW'(r_j) + KW'(1)) == r_k);

    genvar g;
    for (g = 0; g < NB; g++) begin : g_cell
        logic [DIST_W-1:0] ins_cd, rot_cd, n_cd;
        logic [AW-1:0]     ins_ci, rot_ci, n_ci;
        logic              prev_gt, in_k, is_km1;

        assign gt[g]  = (r_n <= KW'(g)) || (r_cd[g] > r_root);
        assign in_k   = (KW'(g) < r_k);
        assign is_km1 = (KW'(g + 1) == r_k);

        if (g == 0) begin : g_first
            assign prev_gt = 1'b0;
            assign ins_cd  = r_root;
            assign ins_ci  = r_i;
        end else begin : g_rest
            assign prev_gt = gt[g-1];
            assign ins_cd  = prev_gt ? r_cd[g-1] : r_root;
            assign ins_ci  = prev_gt ? r_ci[g-1] : r_i;
        end

        if (g == NB - 1) begin : g_end
            assign rot_cd = r_cd[0];
            assign rot_ci = r_ci[0];
        end else begin : g_mid
            assign rot_cd = is_km1 ? r_cd[0] : r_cd[g+1];
            assign rot_ci = is_km1 ? r_ci[0] : r_ci[g+1];
        end

        always_comb begin
            n_cd = r_cd[g];
            n_ci = r_ci[g];
            case (i_cmd.op)
                OP_INS: begin
                    if (in_k && gt[g]) begin
                        n_cd = ins_cd;
                        n_ci = ins_ci;
                    end
                end
                OP_AW5, OP_EMIT: begin
                    if (in_k) begin
                        n_cd = rot_cd;
                        n_ci = rot_ci;
                    end
                end
                default: ;
            endcase
        end

        always_ff @(posedge i_clk) begin
            r_cd[g] <= n_cd;
            r_ci[g] <= n_ci;
        end
    end

    always_comb begin
        dmax_sel = '0;
        for (int j = 0; j < NB; j++) begin
            if (KW'(j + 1) == r_k) dmax_sel = r_cd[j];
        end
    end

    // radius test: scale * dmax > (step * steps) << 37
    logic [56:0] lim;
    logic [64:0] scaled;
    assign lim    = {20'(r_rstep) * 20'(r_rsteps), 37'd0};
    assign scaled = 65'(r_prod) + (r_dmax[32] ? {1'b0, r_scale, 32'd0} : 65'd0);

    always_comb begin
        o_sts.cnt_full    = (r_count == CW'(MAX_PARTICLES));
        o_sts.cnt_zero    = (r_count == '0);
        o_sts.scan_last   = ({1'b0, r_i} == (r_count - CW'(1)));
        o_sts.list_short  = (r_n < r_k);
        o_sts.radius_fail = (r_dmax != '0) && (scaled > 65'(lim));
        o_sts.dmax_zero   = (r_dmax == '0);
        o_sts.j_last      = j_last;
        o_sts.sum_zero    = (r_sum == '0);
        o_sts.sum_wide    = (r_sum[SUM_W-1:32] != '0);
    end

    // control-side registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_i     <= '0;
            r_k     <= KW'(2);
            r_n     <= '0;
            r_j     <= '0;
            r_s     <= '0;
        end else begin
            case (i_cmd.op)
                OP_CLEAR: r_count <= '0;
                OP_LOAD:  r_count <= r_count + CW'(1);
                OP_QINIT: begin
                    r_i <= '0;
                    r_n <= '0;
                    r_k <= k_clamp;
                end
                OP_INS: begin
                    r_i <= r_i + AW'(1);
                    if (r_n < r_k) r_n <= r_n + KW'(1);
                end
                OP_RCMP: begin
                    r_j <= '0;
                    r_s <= '0;
                end
                OP_AW5, OP_EMIT: r_j <= j_last ? '0 : r_j + JW'(1);
                OP_NORM: r_s <= r_s + SH_W'(1);
                default: ;
            endcase
        end
    end

    // datapath payload
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_QINIT: begin
                r_cx <= i_pos_x;
                r_cy <= i_pos_y;
                r_cz <= i_pos_z;
                r_id <= i_centre_id;
            end
            OP_DIF: begin
                r_dx <= abs_diff(pos_rdata[95:64], r_cx);
                r_dy <= abs_diff(pos_rdata[63:32], r_cy);
                r_dz <= abs_diff(pos_rdata[31:0], r_cz);
            end
            OP_SQX: r_prod <= mul_p;
            OP_SQY: begin
                r_acc  <= RAD_W'(r_prod);
                r_prod <= mul_p;
            end
            OP_SQZ: begin
                r_acc  <= r_acc + RAD_W'(r_prod);
                r_prod <= mul_p;
            end
            OP_SQF: begin
                r_rad  <= r_acc + RAD_W'(r_prod);
                r_rem  <= '0;
                r_root <= '0;
            end
            OP_SQRT: begin
                r_rem  <= sq_ge ? 35'(rem2 - 37'(trial)) : 35'(rem2);
                r_root <= {r_root[DIST_W-2:0], sq_ge};
                r_rad  <= {r_rad[RAD_W-3:0], 2'b00};
            end
            OP_CHK:  r_dmax <= dmax_sel;
            OP_RMUL: r_prod <= mul_p;
            OP_RCMP: r_sum  <= '0;
            OP_ADIV0: begin
                r_dsor <= r_dmax;
                r_drem <= r_cd[0] >> 1;
                r_dlo  <= {r_cd[0][0], 31'd0};
                r_quo  <= '0;
            end
            OP_BDIV0: begin
                r_dsor <= {1'b0, r_sum[31:0]};
                r_drem <= {1'b0, r_prod[63:32]};
                r_dlo  <= r_prod[31:0];
                r_quo  <= '0;
            end
            OP_DIV: begin
                r_drem <= d_ge ? 33'(drem2 - {1'b0, r_dsor}) : 33'(drem2);
                r_dlo  <= {r_dlo[30:0], 1'b0};
                r_quo  <= {r_quo[30:0], d_ge};
            end
            OP_W1: r_prod <= mul_p;
            OP_W2: begin
                r_u    <= 31'(r_prod >> 30);
                r_prod <= mul_p;
            end
            OP_W3:   r_w    <= w_next;
            OP_W4:   r_prod <= mul_p;
            OP_AW5:  r_sum  <= r_sum + SUM_W'(term);
            OP_NORM: r_sum  <= r_sum >> 1;
            OP_BMUL: r_prod <= mul_p;
            default: ;
        endcase
    end

    // result register
    logic        r_valid;
    logic [11:0] r_o_idx;
    logic [23:0] r_o_id;
    logic [31:0] r_o_dist, r_o_share;
    logic [1:0]  r_o_status;
    logic        r_o_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= (i_cmd.op == OP_FULL) || (i_cmd.op == OP_ERR) ||
                       (i_cmd.op == OP_EMIT);
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_FULL, OP_ERR: begin
                r_o_idx    <= '0;
                r_o_id     <= (i_cmd.op == OP_FULL) ? i_centre_id : r_id;
                r_o_dist   <= '0;
                r_o_share  <= '0;
                r_o_status <= (i_cmd.op == OP_FULL) ? ST_FULL : i_cmd.err;
                r_o_last   <= 1'b1;
            end
            OP_EMIT: begin
                r_o_idx    <= 12'(r_ci[0]);
                r_o_id     <= r_id;
                r_o_dist   <= r_cd[0][32] ? 32'hFFFF_FFFF : r_cd[0][31:0];
                r_o_share  <= r_quo;
                r_o_status <= ST_OK;
                r_o_last   <= j_last;
            end
            default: ;
        endcase
    end

    assign o_result_valid      = r_valid;
    assign o_neighbor_index    = r_o_idx;
    assign o_echo_id           = r_o_id;
    assign o_neighbor_distance = r_o_dist;
    assign o_share             = r_o_share;
    assign o_status            = r_o_status;
    assign o_last              = r_o_last;

endmodule
